[design/fdtt_pkg.sv]
`default_nettype none
package fdtt_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;

	localparam int DATA_W = 32;
	localparam int CNT_W = 7;
	localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;

	// memory word: valid, key, delta
	localparam int MEM_W = 1 + DATA_W + DATA_W;

	localparam logic [2:0] REQ_CLAIM   = 3'd0;
	localparam logic [2:0] REQ_RELEASE = 3'd1;
	localparam logic [2:0] REQ_EXIT    = 3'd2;
	localparam logic [2:0] REQ_EXIT_GE = 3'd3;
	localparam logic [2:0] REQ_CHECK   = 3'd4;

	typedef struct packed {
		logic        [2:0]        req_type;
		logic signed [DATA_W-1:0] frame_key;
		logic signed [DATA_W-1:0] claim_amount;
		logic signed [DATA_W-1:0] old_sp;
		logic signed [DATA_W-1:0] new_sp;
		logic signed [DATA_W-1:0] master_sp;
		logic signed [DATA_W-1:0] clone_sp;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] current_delta;
		logic                     check_match;
		logic        [CNT_W-1:0]  removed_count;
		logic signed [DATA_W-1:0] bad_frame;
		logic signed [DATA_W-1:0] bad_frame_delta;
		logic                     table_full;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic clr_wr;
		logic rd_en;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic out_block;
	} dp_stat_t;

endpackage
`default_nettype wire

[design/fdtt_ctrl.sv]
`default_nettype none
module fdtt_ctrl #(
	parameter int TABLE_ENTRIES = fdtt_pkg::TABLE_ENTRIES_DEF,
	parameter int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire fdtt_pkg::dp_stat_t stat,
	output fdtt_pkg::ctl_cmd_t      cmd,
	output logic [AW-1:0]           addr
);

	localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);

	fdtt_pkg::state_t state_q, state_n;
	logic [AW-1:0]    cnt_q, cnt_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fdtt_pkg::ST_CLEAR;
			cnt_q   <= '0;
		end else begin
			state_q <= state_n;
			cnt_q   <= cnt_n;
		end
	end

	always_comb begin
		state_n   = state_q;
		cnt_n     = cnt_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			fdtt_pkg::ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (cnt_q == LAST_ADDR) begin
					cnt_n   = '0;
					state_n = fdtt_pkg::ST_IDLE;
				end else begin
					cnt_n = cnt_q + AW'(1);
				end
			end
			fdtt_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					cnt_n    = '0;
					state_n  = fdtt_pkg::ST_SCAN;
				end
			end
			fdtt_pkg::ST_SCAN: begin
				cmd.rd_en = 1'b1;
				if (cnt_q == LAST_ADDR) begin
					cnt_n   = '0;
					state_n = fdtt_pkg::ST_DRAIN;
				end else begin
					cnt_n = cnt_q + AW'(1);
				end
			end
			fdtt_pkg::ST_DRAIN: begin
				state_n = fdtt_pkg::ST_FINISH;
			end
			fdtt_pkg::ST_FINISH: begin
				if (!stat.out_block) begin
					cmd.finish = 1'b1;
					state_n    = fdtt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = fdtt_pkg::ST_CLEAR;
				cnt_n   = '0;
			end
		endcase
	end

	assign addr = cnt_q;

endmodule
`default_nettype wire

[design/fdtt_datapath.sv]
`default_nettype none
module fdtt_datapath #(
	parameter int TABLE_ENTRIES = fdtt_pkg::TABLE_ENTRIES_DEF,
	parameter int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire fdtt_pkg::req_t     req,
	input  wire fdtt_pkg::ctl_cmd_t cmd,
	input  wire logic [AW-1:0]      addr,
	output fdtt_pkg::dp_stat_t      stat,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output fdtt_pkg::rsp_t          rsp
);

	localparam int DW = fdtt_pkg::DATA_W;
	localparam int MW = fdtt_pkg::MEM_W;

	// table memory, one read and one write port
	logic [MW-1:0] mem_q [TABLE_ENTRIES];
	logic [MW-1:0] rd_data_q;
	logic          rd_vld_s1;
	logic [AW-1:0] rd_addr_s1;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [MW-1:0] wr_data;

	// operation operands
	logic [2:0]    op_q;
	logic [DW-1:0] key_q;
	logic [DW-1:0] addend_q;
	logic [DW-1:0] diff_q;

	// scan results
	logic          found_q;
	logic [AW-1:0] found_idx_q;
	logic [DW-1:0] found_delta_q;
	logic          free_q;
	logic [AW-1:0] free_idx_q;
	logic [fdtt_pkg::CNT_W-1:0] rm_cnt_q;
	logic          have_bad_q;
	logic [DW-1:0] bad_key_q;
	logic [DW-1:0] bad_frame_delta_q;

	logic          out_valid_q;
	fdtt_pkg::rsp_t out_data_q;

	logic          e_valid;
	logic [DW-1:0] e_key;
	logic [DW-1:0] e_delta;
	logic          e_hit;
	logic          e_remove;
	logic          e_new_bad;

	logic          fin_wr;
	logic [AW-1:0] fin_addr;
	logic [MW-1:0] fin_data;
	logic [DW-1:0] upd_delta;
	fdtt_pkg::rsp_t result;

	assign e_valid = rd_data_q[MW-1];
	assign e_key   = rd_data_q[2*DW-1:DW];
	assign e_delta = rd_data_q[DW-1:0];
	assign e_hit   = rd_vld_s1 && e_valid && (e_key == key_q);
	assign e_remove = rd_vld_s1 && (op_q == fdtt_pkg::REQ_EXIT_GE) && e_valid
		&& ($signed(e_key) >= $signed(key_q));
	assign e_new_bad = e_remove && (e_delta != '0)
		&& (!have_bad_q || ($signed(e_key) < $signed(bad_key_q)));

	assign upd_delta = found_delta_q + addend_q;

	always_comb begin
		fin_wr   = 1'b0;
		fin_addr = found_idx_q;
		fin_data = '0;
		result   = '0;
		case (op_q)
			fdtt_pkg::REQ_CLAIM, fdtt_pkg::REQ_RELEASE: begin
				if (found_q) begin
					fin_wr   = 1'b1;
					fin_data = {1'b1, key_q, upd_delta};
					result.current_delta = $signed(upd_delta);
				end else if (free_q) begin
					fin_wr   = 1'b1;
					fin_addr = free_idx_q;
					fin_data = {1'b1, key_q, addend_q};
					result.current_delta = $signed(addend_q);
				end else begin
					result.table_full = 1'b1;
				end
			end
			fdtt_pkg::REQ_EXIT: begin
				if (found_q) begin
					fin_wr = 1'b1;
					result.removed_count = fdtt_pkg::CNT_W'(1);
				end
			end
			fdtt_pkg::REQ_EXIT_GE: begin
				result.removed_count   = rm_cnt_q;
				result.bad_frame       = $signed(bad_key_q);
				result.bad_frame_delta = $signed(bad_frame_delta_q);
			end
			default: begin
				// check, and unused types act as a plain read
				result.current_delta = found_q ? $signed(found_delta_q) : '0;
				result.check_match = (op_q == fdtt_pkg::REQ_CHECK)
					&& (diff_q == (found_q ? found_delta_q : '0));
			end
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr;
		wr_data = '0;
		if (cmd.clr_wr) begin
			wr_en = 1'b1;
		end else if (e_remove) begin
			wr_en   = 1'b1;
			wr_addr = rd_addr_s1;
		end else if (cmd.finish && fin_wr) begin
			wr_en   = 1'b1;
			wr_addr = fin_addr;
			wr_data = fin_data;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem_q[addr];
		end
		rd_addr_s1 <= addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
		end
	end

	// operands
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= req.req_type;
			key_q <= req.frame_key;
			if (req.req_type == fdtt_pkg::REQ_CLAIM) begin
				addend_q <= {req.claim_amount[DW-2:0], 1'b0};
			end else begin
				addend_q <= req.new_sp - req.old_sp;
			end
			diff_q <= req.master_sp - req.clone_sp;
		end
	end

	// scan accumulation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q    <= 1'b0;
			free_q     <= 1'b0;
			rm_cnt_q   <= '0;
			have_bad_q <= 1'b0;
		end else if (cmd.load) begin
			found_q    <= 1'b0;
			free_q     <= 1'b0;
			rm_cnt_q   <= '0;
			have_bad_q <= 1'b0;
		end else begin
			if (e_hit && !found_q) begin
				found_q <= 1'b1;
			end
			if (rd_vld_s1 && !e_valid && !free_q) begin
				free_q <= 1'b1;
			end
			if (e_remove && (rm_cnt_q != fdtt_pkg::CNT_MAX)) begin
				rm_cnt_q <= rm_cnt_q + fdtt_pkg::CNT_W'(1);
			end
			if (e_new_bad) begin
				have_bad_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bad_key_q         <= '0;
			bad_frame_delta_q <= '0;
		end else begin
			if (e_hit && !found_q) begin
				found_idx_q   <= rd_addr_s1;
				found_delta_q <= e_delta;
			end
			if (rd_vld_s1 && !e_valid && !free_q) begin
				free_idx_q <= rd_addr_s1;
			end
			if (e_new_bad) begin
				bad_key_q         <= e_key;
				bad_frame_delta_q <= e_delta;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_data_q <= result;
		end
	end

	assign stat.out_block = out_valid_q && !rsp_ready;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_data_q;

endmodule
`default_nettype wire

[design/frame_delta_tracking_table_core.sv]
// frame delta tracking table: one request word in, one response word out
// request channel req / req_valid / req_ready carries the operation, key and
//   stack pointer operands; response channel rsp / rsp_valid / rsp_ready
//   carries current delta, check result, removal report and full flag
// every request scans the whole table through the single memory read port,
//   one entry per cycle, then after a drain step the finish step applies the update
// a new request is accepted only in idle, after the finish step of the previous one
// reset: after arst_n releases, a clearing pass writes every entry empty
//   with req_ready low; then the table is empty
// stall: the response sits in an output register; a new request is taken
//   and scanned while it waits, and the finish step holds until the
//   receiver has taken the previous response
`default_nettype none
module frame_delta_tracking_table_core #(
	parameter int TABLE_ENTRIES = fdtt_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire fdtt_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output fdtt_pkg::rsp_t      rsp
);

	// table index width, at least one bit
	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	fdtt_pkg::ctl_cmd_t cmd;
	fdtt_pkg::dp_stat_t stat;
	logic [AW-1:0]      addr;

	// sequencer: clear pass, scan, drain, finish
	fdtt_ctrl #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.AW           (AW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.stat     (stat),
		.cmd      (cmd),
		.addr     (addr)
	);

	// table memory, scan accumulators and output register
	fdtt_datapath #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.AW           (AW)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.addr     (addr),
		.stat     (stat),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

endmodule
`default_nettype wire
